### hdl/ftfpg_pkg.sv
// Shared types and constants for the frame-to-frame proximity gate.
// No dependencies; imported by frame_to_frame_proximity_gate_core.
package ftfpg_pkg;

    localparam int FIELD_W = 12;                  // x, y, radius and limit width
    localparam int DATA_W  = 40;                  // three 12-bit fields, padded to bytes
    localparam int SQ_W    = 2 * FIELD_W;         // one squared difference
    localparam int SUM_W   = SQ_W + 1;            // sum of two squares

    localparam logic [FIELD_W-1:0] LIMIT_RESET = 12'd25;

    // tuser codes on the input side
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_EOF   = 1'b1;

    typedef logic [FIELD_W-1:0] coord_t;

    // one stored point: x in the low half, y in the high half
    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

endpackage

### hdl/frame_to_frame_proximity_gate_core.sv
// Frame-to-frame proximity gate: top level with the two-bank point store.
// Depends on ftfpg_pkg.
//
// Points (x, y, radius) of one frame arrive as beats with tuser = 0; a beat with
// tuser = 1 ends the frame and always yields one marker beat (tuser = 1, tdata
// zero). A point beat yields an output beat only when it lies strictly closer
// than distance_limit to some point of the previous frame; the first frame after
// reset yields markers only. Every point of a frame, up to MAX_POINTS, is written
// into one bank of a single-port-write, single-port-read memory; the frame end
// swaps banks. Before the next accept, a point beat is compared with each of the P
// points stored for the previous frame (none when P is zero): the previous bank is
// read one entry per cycle through the memory read port and each entry then
// goes through difference, square and compare stages. A stalled output adds
// its stall to the item that has a result to load. The block takes one item
// at a time; a result waiting in the output register does not stall input
// until the next result is ready.
module frame_to_frame_proximity_gate_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: distance_limit
    input  logic                         cfg_wr_en,
    input  logic [ftfpg_pkg::FIELD_W-1:0] cfg_wr_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ftfpg_pkg::DATA_W-1:0] s_axis_tdata,  // pos_x, pos_y, size_radius, pad
    input  logic                         s_axis_tuser,  // op
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ftfpg_pkg::DATA_W-1:0] m_axis_tdata,  // out_x, out_y, out_radius, pad
    output logic                         m_axis_tuser   // frame_done
);
    import ftfpg_pkg::*;

    localparam int STORE_DEPTH = 2 * MAX_POINTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    coord_t           limit_reg;
    logic [SQ_W-1:0]  lim2_reg;
    logic             bank_reg;
    logic [CNT_W-1:0] cur_count_reg;
    logic [CNT_W-1:0] prev_count_reg;
    logic [CNT_W-1:0] scan_idx_reg;

    coord_t           px_reg, py_reg, pr_reg;
    logic             pend_done_reg;
    logic             hit_reg;

    // scan pipeline
    logic             rd_vld_reg, d_vld_reg, sq_vld_reg;
    point_t           rd_data_reg;
    coord_t           dx_reg, dy_reg;
    logic [SQ_W-1:0]  dx2_reg, dy2_reg;

    logic             out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic             out_user_reg;

    point_t           mem [0:STORE_DEPTH-1];

    logic             accept;
    logic             in_op;
    point_t           in_pt;
    coord_t           in_r;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    logic             out_free;
    logic             emit_now;
    logic             scan_drained;
    logic [SUM_W-1:0] dist2;
    coord_t           diff_x, diff_y;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_pt.x       = s_axis_tdata[FIELD_W-1:0];
    assign in_pt.y       = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign in_r          = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];

    // reads hit the previous bank, writes the current one: never the same entry
    assign rd_en   = (state_reg == ST_SCAN) && (scan_idx_reg < prev_count_reg);
    assign rd_addr = bank_reg ? ADDR_W'(scan_idx_reg[IDX_W-1:0])
                              : ADDR_W'(MAX_POINTS) + ADDR_W'(scan_idx_reg[IDX_W-1:0]);
    assign wr_en   = accept && (in_op == OP_POINT) && (cur_count_reg < CNT_W'(MAX_POINTS));
    assign wr_addr = bank_reg ? ADDR_W'(MAX_POINTS) + ADDR_W'(cur_count_reg[IDX_W-1:0])
                              : ADDR_W'(cur_count_reg[IDX_W-1:0]);

    assign diff_x = (px_reg >= rd_data_reg.x) ? px_reg - rd_data_reg.x : rd_data_reg.x - px_reg;
    assign diff_y = (py_reg >= rd_data_reg.y) ? py_reg - rd_data_reg.y : rd_data_reg.y - py_reg;
    assign dist2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    assign scan_drained = !rd_en && !rd_vld_reg && !d_vld_reg && !sq_vld_reg;
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign emit_now     = (state_reg == ST_EMIT) && (pend_done_reg || hit_reg) && out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_pt;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_op == OP_EOF) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_drained)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!(pend_done_reg || hit_reg) || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            bank_reg       <= 1'b0;
            cur_count_reg  <= '0;
            prev_count_reg <= '0;
            scan_idx_reg   <= '0;
            pend_done_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            rd_vld_reg     <= 1'b0;
            d_vld_reg      <= 1'b0;
            sq_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            d_vld_reg  <= rd_vld_reg;
            sq_vld_reg <= d_vld_reg;

            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            if (accept)
            begin
                scan_idx_reg  <= '0;
                hit_reg       <= 1'b0;
                pend_done_reg <= (in_op == OP_EOF);
                if (in_op == OP_EOF)
                begin
                    bank_reg       <= ~bank_reg;
                    prev_count_reg <= cur_count_reg;
                    cur_count_reg  <= '0;
                end
                else if (wr_en)
                begin
                    cur_count_reg <= cur_count_reg + 1'b1;
                end
            end
            else
            begin
                if (rd_en)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (sq_vld_reg && (dist2 < {1'b0, lim2_reg}))
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= in_pt.x;
            py_reg   <= in_pt.y;
            pr_reg   <= in_r;
            lim2_reg <= limit_reg * limit_reg;
        end
        dx_reg  <= diff_x;
        dy_reg  <= diff_y;
        dx2_reg <= dx_reg * dx_reg;
        dy2_reg <= dy_reg * dy_reg;
        if (emit_now)
        begin
            out_user_reg <= pend_done_reg;
            if (pend_done_reg)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= {{(DATA_W - 3*FIELD_W){1'b0}}, pr_reg, py_reg, px_reg};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // reads stay inside the previous frame's written entries
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (prev_count_reg <= CNT_W'(MAX_POINTS)))
        else $error("scan reads past the previous frame's points");

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_count_reg <= CNT_W'(MAX_POINTS))
        else $error("current point count exceeds capacity");

    // a match can only appear while the scan pipeline runs
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> $past(sq_vld_reg))
        else $error("match flag set outside the compare stage");

    // a result is never loaded over a beat that is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !emit_now)
        else $error("output register overwritten while stalled");
`endif

endmodule
